/* hw/rtl/sit_pkg.sv */
// types and constants shared by the sorted ipv4 insertion table
// no dependencies
package sit_pkg;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;

    typedef struct packed {
        logic        opcode;
        logic [31:0] address;
        logic [7:0]  read_index;
    } req_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [8:0]  position;
        logic [31:0] read_address;
        logic [8:0]  entry_count;
    } rsp_item_t;

endpackage

/* hw/rtl/sit_ram.sv */
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
module sit_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/sorted_ipv4_insert_table_top.sv */
// channel  direction  payload           handshake
// req      in         sit_pkg::req_item_t  req_valid / req_stall
// rsp      out        sit_pkg::rsp_item_t  rsp_valid / rsp_stall
//
// insert: accept, then shift each entry above the insert point up by one (up to the
// entry count), then write the new address (compare stop or place at index 0), then
// load the result register; the single ram read port
// walks the table top down
// read: ram read, capture, result; full table or bad index: straight to the result
// reset clears the state, the count and the output valid flag only; the entry ram is never cleared
// a waiting result does not block the next item from being accepted
// holds sorted entries in sit_ram, uses sit_pkg
module sorted_ipv4_insert_table_top #(
    parameter int DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  sit_pkg::req_item_t req_item,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output sit_pkg::rsp_item_t rsp_item
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > 8) ? CW : 8;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SHIFT  = 3'd1;
    localparam logic [2:0] S_PLACE  = 3'd2;
    localparam logic [2:0] S_RDWAIT = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [XW-1:0] pos_reg, pos_next;
    logic [31:0] addr_reg, addr_next;
    logic [31:0] rdat_reg, rdat_next;
    logic [1:0]  status_reg, status_next;
    logic        out_valid_reg, out_valid_next;
    sit_pkg::rsp_item_t out_reg, out_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    logic          req_take;
    logic          out_free;
    logic [XW-1:0] ridx_x;
    logic [XW-1:0] count_x;

    sit_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign ridx_x    = XW'(req_item.read_index);
    assign count_x   = XW'(count_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        pos_next       = pos_reg;
        addr_next      = addr_reg;
        rdat_next      = rdat_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = ptr_reg + 1'b1;
        ram_wdata      = addr_reg;
        ram_raddr      = ptr_reg - 1'b1;

        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_item.opcode == sit_pkg::OP_INSERT)
                begin
                    ram_raddr = AW'(count_reg - 1'b1);
                end
                else
                begin
                    ram_raddr = ridx_x[AW-1:0];
                end
                if (req_take)
                begin
                    addr_next   = req_item.address;
                    rdat_next   = '0;
                    status_next = sit_pkg::ST_OK;
                    if (req_item.opcode == sit_pkg::OP_INSERT)
                    begin
                        pos_next = '0;
                        ptr_next = AW'(count_reg - 1'b1);
                        if (count_reg == CW'(DEPTH))
                        begin
                            status_next = sit_pkg::ST_FULL;
                            state_next  = S_DONE;
                        end
                        else if (count_reg == '0)
                        begin
                            state_next = S_PLACE;
                        end
                        else
                        begin
                            state_next = S_SHIFT;
                        end
                    end
                    else
                    begin
                        pos_next = ridx_x;
                        if (ridx_x < count_x)
                        begin
                            state_next = S_RDWAIT;
                        end
                        else
                        begin
                            status_next = sit_pkg::ST_BAD_INDEX;
                            state_next  = S_DONE;
                        end
                    end
                end
            end

            // ram_rdata holds the entry at ptr_reg; next read is ptr_reg - 1
            S_SHIFT:
            begin
                ram_we = 1'b1;
                if (ram_rdata > addr_reg)
                begin
                    ram_wdata = ram_rdata;
                    ptr_next  = ptr_reg - 1'b1;
                    if (ptr_reg == '0)
                    begin
                        pos_next   = '0;
                        state_next = S_PLACE;
                    end
                end
                else
                begin
                    ram_wdata  = addr_reg;
                    pos_next   = XW'(ptr_reg) + 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = S_DONE;
                end
            end

            S_PLACE:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = addr_reg;
                count_next = count_reg + 1'b1;
                state_next = S_DONE;
            end

            S_RDWAIT:
            begin
                rdat_next  = ram_rdata;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_next.status       = status_reg;
                    out_next.position     = 9'(pos_reg);
                    out_next.read_address = rdat_reg;
                    out_next.entry_count  = 9'(count_reg);
                    state_next            = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        pos_reg    <= pos_next;
        addr_reg   <= addr_next;
        rdat_reg   <= rdat_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_reg;

endmodule
